@@ rtl/hvst_pkg.sv @@
// Shared types, constants and helpers of the hashed version slot table.
// Used by the controller, the datapath and the top level; depends on nothing.
package hvst_pkg;

	localparam int unsigned WORD_W     = 64;
	localparam int unsigned HALF_W     = 32;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned COL_W      = 32;
	localparam int unsigned NBYTES_W   = 4;
	localparam int unsigned OUT_SLOT_W = 10;
	localparam int unsigned FMIX_SHIFT = 33;

	localparam logic [WORD_W-1:0] FMIX_K1 = 64'hff51_afd7_ed55_8ccd;
	localparam logic [WORD_W-1:0] FMIX_K2 = 64'hc4ce_b9fe_1a85_ec53;

	localparam logic [NBYTES_W-1:0] WORD_BYTES_MAX = 4'd8;

	// The slot remainder takes this many hash bits per cycle.
	localparam int unsigned MOD_BITS   = 4;
	localparam int unsigned MOD_STEPS  = WORD_W / MOD_BITS;
	localparam int unsigned MOD_CNT_W  = $clog2(MOD_STEPS);
	localparam logic [MOD_CNT_W-1:0] MOD_CNT_LAST = MOD_CNT_W'(MOD_STEPS - 1);

	localparam int unsigned CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HASH_SEED     = 1'b0,
		REG_LOCK_TAG_MASK = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NOP    = 4'd0,
		OP_CLEAR  = 4'd1,
		OP_LOAD   = 4'd2,
		OP_PRE    = 4'd3,
		OP_M0     = 4'd4,
		OP_M1     = 4'd5,
		OP_M2     = 4'd6,
		OP_M3     = 4'd7,
		OP_MID    = 4'd8,
		OP_POST   = 4'd9,
		OP_MOD    = 4'd10,
		OP_READ   = 4'd11,
		OP_DECIDE = 4'd12
	} dp_op_t;

	typedef enum logic [1:0] {
		MIX_SEED_DB = 2'd0,
		MIX_COL     = 2'd1,
		MIX_WORD    = 2'd2,
		MIX_LEN     = 2'd3
	} mix_sel_t;

	typedef struct packed {
		dp_op_t   op;
		mix_sel_t sel;
		logic     k2;
	} dp_cmd_t;

	typedef struct packed {
		logic mid;
		logic in_empty;
		logic in_last;
		logic q_empty;
		logic q_last;
		logic clear_done;
		logic out_free;
	} dp_status_t;

	function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
		return v ^ (v >> FMIX_SHIFT);
	endfunction

endpackage

@@ rtl/hashed_version_slot_table_core.sv @@
// Top level of the hashed version slot table.
// Instantiates hvst_ctrl and hvst_datapath; depends on hvst_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | req_type db_handle column_id key_word
//           |                      | word_bytes key_last version
//   out     | out_valid / out_stall| ok slot_index
//   cfg     | cfg_we               | cfg_index cfg_data
//
// Each fmix64 round runs on the shared 32x32 multiplier. A beat is accepted
// in the idle state and then runs one round per mix: two rounds on the first
// word of a request, one for a word with bytes, one for the length on the
// last word, which then runs the serial slot remainder, the table read and the
// decide step. After reset a clearing pass writes all slots before the first beat.
// A result waits in the output register under out_stall while the next beat works.
module hashed_version_slot_table_core
	import hvst_pkg::*;
#(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   req_type,
	input  logic [WORD_W-1:0]      db_handle,
	input  logic [COL_W-1:0]       column_id,
	input  logic [WORD_W-1:0]      key_word,
	input  logic [NBYTES_W-1:0]    word_bytes,
	input  logic                   key_last,
	input  logic [WORD_W-1:0]      version,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   ok,
	output logic [OUT_SLOT_W-1:0]  slot_index
);

	dp_cmd_t    cmd;
	dp_status_t stat;
	logic       ready;

	assign in_stall = !ready;

	hvst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.ready    (ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hvst_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.db_handle  (db_handle),
		.column_id  (column_id),
		.key_word   (key_word),
		.word_bytes (word_bytes),
		.key_last   (key_last),
		.version    (version),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.slot_index (slot_index)
	);

endmodule

@@ rtl/hvst_datapath.sv @@
// Datapath of the hashed version slot table: hash registers, shared 32x32
// multiplier, serial slot remainder, version memory and result register.
// Depends on hvst_pkg; sequenced by hvst_ctrl.
module hvst_datapath
	import hvst_pkg::*;
#(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_status_t                stat,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [WORD_W-1:0]         cfg_data,
	input  logic                      req_type,
	input  logic [WORD_W-1:0]         db_handle,
	input  logic [COL_W-1:0]          column_id,
	input  logic [WORD_W-1:0]         key_word,
	input  logic [NBYTES_W-1:0]       word_bytes,
	input  logic                      key_last,
	input  logic [WORD_W-1:0]         version,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      ok,
	output logic [OUT_SLOT_W-1:0]     slot_index
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW:0]   SLOT_MOD  = (IW+1)'(SLOT_COUNT);
	localparam logic [IW-1:0] SLOT_LAST = IW'(SLOT_COUNT - 1);

	logic [WORD_W-1:0] seed_q, mask_q;
	logic              mid_q, out_valid_q;
	logic [IW-1:0]     clr_q;

	logic [WORD_W-1:0] db_q, word_q, ver_q, h_q, v_q, prod_q, acc_q, modsh_q, rd_q;
	logic [COL_W-1:0]  col_q;
	logic [LEN_W-1:0]  len_q;
	logic              nb_zero_q, last_q, req_q, ok_q;
	logic [IW-1:0]     rem_q;
	logic [OUT_SLOT_W-1:0] slot_q;

	logic [WORD_W-1:0] mem [SLOT_COUNT];

	logic [NBYTES_W-1:0] nbc;
	logic [WORD_W-1:0]   word_masked;
	logic [LEN_W-1:0]    len_base;
	logic [WORD_W-1:0]   mix_x;
	logic [WORD_W-1:0]   fmix_k;
	logic [HALF_W-1:0]   mul_a, mul_b;
	logic [WORD_W-1:0]   prod_c;
	logic [WORD_W-1:0]   acc_post;
	logic [IW-1:0]       rem_next;
	logic                need, cur_lock, ok_c, mem_we;
	logic [IW-1:0]       mem_addr;
	logic [WORD_W-1:0]   mem_wdata;
	logic [IW+OUT_SLOT_W-1:0] slot_wide;

	assign nbc = (word_bytes > WORD_BYTES_MAX) ? WORD_BYTES_MAX : word_bytes;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			word_masked[8*b +: 8] = (NBYTES_W'(b) < nbc) ? key_word[8*b +: 8] : 8'h00;
		end
	end

	assign len_base = mid_q ? len_q : '0;

	always_comb begin
		unique case (cmd.sel)
			MIX_SEED_DB: mix_x = seed_q ^ db_q;
			MIX_COL:     mix_x = h_q ^ {{(WORD_W-COL_W){1'b0}}, col_q};
			MIX_WORD:    mix_x = h_q ^ word_q;
			MIX_LEN:     mix_x = h_q ^ {{(WORD_W-LEN_W){1'b0}}, len_q};
		endcase
	end

	assign fmix_k = cmd.k2 ? FMIX_K2 : FMIX_K1;
	assign mul_a  = (cmd.op == OP_M1) ? v_q[WORD_W-1:HALF_W] : v_q[HALF_W-1:0];
	assign mul_b  = (cmd.op == OP_M2) ? fmix_k[WORD_W-1:HALF_W] : fmix_k[HALF_W-1:0];
	assign prod_c = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
	assign acc_post = xorshift(acc_q);

	always_comb begin
		logic [IW:0] cand;
		logic [IW-1:0] r;
		r = rem_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			cand = {r, modsh_q[WORD_W-1-i]};
			if (cand >= SLOT_MOD) begin
				cand = cand - SLOT_MOD;
			end
			r = cand[IW-1:0];
		end
		rem_next = r;
	end

	assign need     = (ver_q != '0) && ((ver_q & mask_q) == '0);
	assign cur_lock = (rd_q & mask_q) != '0;
	assign ok_c     = need && (req_q ? !cur_lock : (rd_q == ver_q));

	assign mem_we    = (cmd.op == OP_CLEAR) || ((cmd.op == OP_DECIDE) && req_q && ok_c);
	assign mem_addr  = (cmd.op == OP_CLEAR) ? clr_q : rem_q;
	assign mem_wdata = (cmd.op == OP_CLEAR) ? '0 : ver_q;
	assign slot_wide = {{OUT_SLOT_W{1'b0}}, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			mask_q      <= 64'h8000_0000_0000_0000;
			mid_q       <= 1'b0;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_HASH_SEED:     seed_q <= cfg_data;
					REG_LOCK_TAG_MASK: mask_q <= cfg_data;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				mid_q <= !key_last;
			end
			if (cmd.op == OP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.op == OP_DECIDE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				db_q      <= db_handle;
				col_q     <= column_id;
				word_q    <= word_masked;
				nb_zero_q <= (nbc == '0);
				last_q    <= key_last;
				req_q     <= req_type;
				ver_q     <= version;
				len_q     <= len_base + {{(LEN_W-NBYTES_W){1'b0}}, nbc};
			end
			OP_PRE: v_q <= xorshift(mix_x);
			OP_M0:  prod_q <= prod_c;
			OP_M1: begin
				acc_q  <= prod_q;
				prod_q <= prod_c;
			end
			OP_M2: begin
				acc_q  <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
				prod_q <= prod_c;
			end
			OP_M3:  acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
			OP_MID: v_q <= acc_post;
			OP_POST: begin
				h_q     <= acc_post;
				modsh_q <= acc_post;
				rem_q   <= '0;
			end
			OP_MOD: begin
				rem_q   <= rem_next;
				modsh_q <= modsh_q << MOD_BITS;
			end
			OP_DECIDE: begin
				ok_q   <= ok_c;
				slot_q <= slot_wide[OUT_SLOT_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (cmd.op == OP_READ) begin
			rd_q <= mem[rem_q];
		end
	end

	assign stat.mid        = mid_q;
	assign stat.in_empty   = (word_bytes == '0);
	assign stat.in_last    = key_last;
	assign stat.q_empty    = nb_zero_q;
	assign stat.q_last     = last_q;
	assign stat.clear_done = (clr_q == SLOT_LAST);
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign slot_index = slot_q;

endmodule

@@ rtl/hvst_ctrl.sv @@
// Controller of the hashed version slot table: one-hot sequencer that steps
// the datapath through clearing, hash mixing, slot remainder and table access.
// Depends on hvst_pkg.
module hvst_ctrl
	import hvst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       ready,
	input  dp_status_t stat,
	output dp_cmd_t    cmd
);

	typedef enum logic [11:0] {
		S_CLEAR  = 12'b0000_0000_0001,
		S_IDLE   = 12'b0000_0000_0010,
		S_PRE    = 12'b0000_0000_0100,
		S_M0     = 12'b0000_0000_1000,
		S_M1     = 12'b0000_0001_0000,
		S_M2     = 12'b0000_0010_0000,
		S_M3     = 12'b0000_0100_0000,
		S_MID    = 12'b0000_1000_0000,
		S_POST   = 12'b0001_0000_0000,
		S_MOD    = 12'b0010_0000_0000,
		S_READ   = 12'b0100_0000_0000,
		S_DECIDE = 12'b1000_0000_0000
	} state_t;

	state_t             state_q, state_d;
	mix_sel_t           sel_q, sel_d;
	logic               second_q, second_d;
	logic [MOD_CNT_W-1:0] cnt_q, cnt_d;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		second_d = second_q;
		cnt_d    = cnt_q;
		cmd      = '{op: OP_NOP, sel: sel_q, k2: second_q};
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				second_d = 1'b0;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					priority if (!stat.mid) begin
						sel_d   = MIX_SEED_DB;
						state_d = S_PRE;
					end else if (!stat.in_empty) begin
						sel_d   = MIX_WORD;
						state_d = S_PRE;
					end else if (stat.in_last) begin
						sel_d   = MIX_LEN;
						state_d = S_PRE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_PRE: begin
				cmd.op  = OP_PRE;
				state_d = S_M0;
			end
			S_M0: begin
				cmd.op  = OP_M0;
				state_d = S_M1;
			end
			S_M1: begin
				cmd.op  = OP_M1;
				state_d = S_M2;
			end
			S_M2: begin
				cmd.op  = OP_M2;
				state_d = S_M3;
			end
			S_M3: begin
				cmd.op = OP_M3;
				if (second_q) begin
					state_d = S_POST;
				end else begin
					state_d = S_MID;
				end
			end
			S_MID: begin
				cmd.op   = OP_MID;
				second_d = 1'b1;
				state_d  = S_M0;
			end
			S_POST: begin
				cmd.op   = OP_POST;
				second_d = 1'b0;
				cnt_d    = '0;
				unique case (sel_q)
					MIX_SEED_DB: begin
						sel_d   = MIX_COL;
						state_d = S_PRE;
					end
					MIX_COL: begin
						priority if (!stat.q_empty) begin
							sel_d   = MIX_WORD;
							state_d = S_PRE;
						end else if (stat.q_last) begin
							sel_d   = MIX_LEN;
							state_d = S_PRE;
						end else begin
							state_d = S_IDLE;
						end
					end
					MIX_WORD: begin
						if (stat.q_last) begin
							sel_d   = MIX_LEN;
							state_d = S_PRE;
						end else begin
							state_d = S_IDLE;
						end
					end
					MIX_LEN: state_d = S_MOD;
				endcase
			end
			S_MOD: begin
				cmd.op = OP_MOD;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_LAST) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.op  = OP_READ;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.out_free) begin
					cmd.op  = OP_DECIDE;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			sel_q    <= MIX_SEED_DB;
			second_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q  <= state_d;
			sel_q    <= sel_d;
			second_q <= second_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

@@ dv/tb_hashed_version_slot_table_core.sv @@
// Self-checking testbench for hashed_version_slot_table_core: directed and random key requests,
// register changes between phases, and random sender gaps and receiver stalls.
// Depends on hvst_pkg and the core RTL; every slot verdict is predicted inside this file.
`timescale 1ns / 1ps

module tb_hashed_version_slot_table_core;
	import hvst_pkg::*;

	localparam int unsigned SLOTS         = 1024;
	localparam int unsigned KEY_WORDS     = 4;
	localparam int unsigned BOOK_DEPTH    = 24;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned LIMIT_CYCLES  = 600000;

	localparam logic REQ_VERIFY   = 1'b0;
	localparam logic REQ_POPULATE = 1'b1;

	localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hff51_afd7_ed55_8ccd;
	localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'hc4ce_b9fe_1a85_ec53;
	localparam logic [WORD_W-1:0] TOP_BIT     = 64'h8000_0000_0000_0000;
	localparam logic [WORD_W-1:0] MAX_UNTAGGED = 64'h7fff_ffff_ffff_ffff;

	typedef struct packed {
		logic                req_type;
		logic [WORD_W-1:0]   db_handle;
		logic [COL_W-1:0]    column_id;
		logic [WORD_W-1:0]   key_word;
		logic [NBYTES_W-1:0] word_bytes;
		logic                key_last;
		logic [WORD_W-1:0]   version;
	} beat_t;

	typedef struct packed {
		logic [WORD_W-1:0]                     db;
		logic [COL_W-1:0]                      col;
		logic [2:0]                            nw;
		logic [KEY_WORDS-1:0][WORD_W-1:0]      w;
		logic [KEY_WORDS-1:0][NBYTES_W-1:0]    nb;
	} key_t;

	typedef struct packed {
		key_t              key;
		logic [WORD_W-1:0] ver;
	} book_entry_t;

	typedef struct packed {
		logic                  ok;
		logic [OUT_SLOT_W-1:0] slot;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [WORD_W-1:0]      cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic                   req_type;
	logic [WORD_W-1:0]      db_handle;
	logic [COL_W-1:0]       column_id;
	logic [WORD_W-1:0]      key_word;
	logic [NBYTES_W-1:0]    word_bytes;
	logic                   key_last;
	logic [WORD_W-1:0]      version;
	logic                   out_valid;
	logic                   out_stall;
	logic                   ok;
	logic [OUT_SLOT_W-1:0]  slot_index;

	logic [WORD_W-1:0] seed_reg      = '0;
	logic [WORD_W-1:0] lock_mask_reg = TOP_BIT;
	logic [WORD_W-1:0] chain_hash    = '0;
	logic [LEN_W-1:0]  chain_len     = '0;
	logic              in_key        = 1'b0;
	logic [WORD_W-1:0] slot_mem [SLOTS];

	verdict_t    slot_verdicts[$];
	book_entry_t key_book[$];

	int unsigned beats_sent  = 0;
	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left  = 0;
	int unsigned rx_hold_req = 0;
	bit          tx_gaps_on  = 1'b1;
	bit          rx_stall_on = 1'b1;

	hashed_version_slot_table_core #(.SLOT_COUNT(SLOTS)) u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] fmix(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] x;
		x = v ^ (v >> 33);
		x = x * MIX_MUL_A;
		x = x ^ (x >> 33);
		x = x * MIX_MUL_B;
		return x ^ (x >> 33);
	endfunction

	function automatic logic [WORD_W-1:0] rand64();
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [WORD_W-1:0] make_version();
		logic [WORD_W-1:0] v;
		int unsigned r;
		v = rand64();
		r = $urandom_range(0, 9);
		if (r == 0) begin
			v = '0;
		end else if (r == 1) begin
			v = v | (lock_mask_reg & ({$urandom(), $urandom()} | TOP_BIT));
		end else begin
			v = v & ~lock_mask_reg;
		end
		return v;
	endfunction

	function automatic key_t one_word(input logic [WORD_W-1:0] db, input logic [COL_W-1:0] col,
			input logic [WORD_W-1:0] w, input logic [NBYTES_W-1:0] nb);
		key_t k;
		k = '0;
		k.db = db;
		k.col = col;
		k.nw = 3'd1;
		k.w[0] = w;
		k.nb[0] = nb;
		return k;
	endfunction

	function automatic key_t make_key();
		key_t k;
		int i;
		int unsigned r;
		k = '0;
		k.db = rand64();
		k.col = $urandom();
		k.nw = ($urandom_range(0, 4) == 0) ? $urandom_range(3, KEY_WORDS) : $urandom_range(1, 2);
		for (i = 0; i < k.nw; i++) begin
			k.w[i] = rand64();
			r = $urandom_range(0, 9);
			if (i == k.nw - 1) begin
				k.nb[i] = (r == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			end else if (r == 0) begin
				k.nb[i] = '0;
			end else if (r == 1) begin
				k.nb[i] = $urandom_range(1, 7);
			end else if (r == 2) begin
				k.nb[i] = $urandom_range(9, 15);
			end else begin
				k.nb[i] = WORD_BYTES_MAX;
			end
		end
		return k;
	endfunction

	// Advances the hash chain by one beat and, on the last word, settles the slot.
	task automatic hash_and_apply(input beat_t b);
		logic [WORD_W-1:0]   h;
		logic [WORD_W-1:0]   w;
		logic [WORD_W-1:0]   slot;
		logic [NBYTES_W-1:0] n;
		verdict_t            v;
		if (!in_key) begin
			h = fmix(seed_reg ^ b.db_handle);
			h = fmix(h ^ {{(WORD_W-COL_W){1'b0}}, b.column_id});
			chain_len = '0;
		end else begin
			h = chain_hash;
		end
		n = (b.word_bytes > WORD_BYTES_MAX) ? WORD_BYTES_MAX : b.word_bytes;
		if (n != 0) begin
			w = b.key_word;
			if (n < WORD_BYTES_MAX) begin
				w = w & ((64'd1 << (8 * n)) - 64'd1);
			end
			h = fmix(h ^ w);
			chain_len = chain_len + LEN_W'(n);
		end
		if (!b.key_last) begin
			chain_hash = h;
			in_key = 1'b1;
		end else begin
			h = fmix(h ^ {{(WORD_W-LEN_W){1'b0}}, chain_len});
			slot = h % SLOTS;
			chain_hash = h;
			in_key = 1'b0;
			v.ok = 1'b0;
			v.slot = slot[OUT_SLOT_W-1:0];
			if (b.version != 0 && (b.version & lock_mask_reg) == 0) begin
				if (b.req_type == REQ_VERIFY) begin
					v.ok = (slot_mem[slot] == b.version);
				end else if ((slot_mem[slot] & lock_mask_reg) == 0) begin
					slot_mem[slot] = b.version;
					v.ok = 1'b1;
				end
			end
			slot_verdicts.push_back(v);
		end
	endtask

	task automatic send_beat(input beat_t b);
		in_valid <= 1'b1;
		req_type <= b.req_type;
		db_handle <= b.db_handle;
		column_id <= b.column_id;
		key_word <= b.key_word;
		word_bytes <= b.word_bytes;
		key_last <= b.key_last;
		version <= b.version;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		hash_and_apply(b);
		beats_sent++;
		if (tx_gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8))
					@(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Fields that the block ignores on a given word carry random values.
	task automatic send_request(input key_t k, input logic rt, input logic [WORD_W-1:0] ver);
		beat_t b;
		int    i;
		for (i = 0; i < k.nw; i++) begin
			b.key_last = (i == k.nw - 1);
			b.req_type = b.key_last ? rt : 1'($urandom_range(0, 1));
			b.db_handle = (i == 0) ? k.db : rand64();
			b.column_id = (i == 0) ? k.col : $urandom();
			b.key_word = k.w[i];
			b.word_bytes = k.nb[i];
			b.version = b.key_last ? ver : rand64();
			send_beat(b);
		end
	endtask

	task automatic wait_drained(input bit settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (slot_verdicts.size() != 0) begin
			@(posedge clk);
		end
		if (settle) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic set_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_HASH_SEED) begin
			seed_reg = val;
			key_book.delete();
		end else begin
			lock_mask_reg = val;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_traffic(input int unsigned beats);
		int unsigned stop_at;
		key_t        k;
		logic        rt;
		logic [WORD_W-1:0] ver;
		book_entry_t e;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			rt = $urandom_range(0, 1);
			if (key_book.size() != 0 && $urandom_range(0, 1) == 1) begin
				e = key_book[$urandom_range(0, key_book.size() - 1)];
				k = e.key;
				ver = ($urandom_range(0, 9) < 6) ? e.ver : make_version();
			end else begin
				k = make_key();
				ver = make_version();
			end
			send_request(k, rt, ver);
			if (rt == REQ_POPULATE) begin
				e.key = k;
				e.ver = ver;
				key_book.push_back(e);
				if (key_book.size() > BOOK_DEPTH) begin
					void'(key_book.pop_front());
				end
			end
		end
	endtask

	task automatic test_directed_cases();
		key_t ka, kb, kc, kd, ke;
		logic [WORD_W-1:0] vd, ve;
		ka = one_word('0, '0, '1, WORD_BYTES_MAX);
		send_request(ka, REQ_POPULATE, MAX_UNTAGGED);
		send_request(ka, REQ_VERIFY, MAX_UNTAGGED);
		send_request(ka, REQ_VERIFY, 64'd1);
		send_request(ka, REQ_POPULATE, MAX_UNTAGGED);
		send_request(ka, REQ_VERIFY, '0);
		send_request(ka, REQ_POPULATE, '0);
		send_request(ka, REQ_POPULATE, '1);
		send_request(ka, REQ_VERIFY, '1);
		kb = one_word('1, '1, '1, '0);
		send_request(kb, REQ_POPULATE, 64'd1);
		send_request(kb, REQ_VERIFY, 64'd1);
		// Byte counts above eight hash like a full word, so this lands on ka's slot.
		kc = one_word('0, '0, '1, 4'd15);
		send_request(kc, REQ_VERIFY, MAX_UNTAGGED);
		kd = one_word({$urandom(), $urandom()}, $urandom(), {$urandom(), $urandom()}, '0);
		kd.nw = 3'd3;
		kd.w[1] = '1;
		kd.nb[1] = 4'd3;
		kd.w[2] = {$urandom(), $urandom()};
		kd.nb[2] = 4'd5;
		vd = {$urandom(), $urandom()} & MAX_UNTAGGED;
		send_request(kd, REQ_POPULATE, vd);
		send_request(kd, REQ_VERIFY, vd);
		ke = one_word({$urandom(), $urandom()}, $urandom(), {$urandom(), $urandom()},
			WORD_BYTES_MAX);
		ke.nw = 3'd2;
		ke.w[1] = '1;
		ke.nb[1] = '0;
		ve = {$urandom(), $urandom()} & MAX_UNTAGGED;
		send_request(ke, REQ_POPULATE, ve);
		send_request(ke, REQ_VERIFY, ve);
	endtask

	task automatic test_lock_tags();
		key_t kf, kg;
		kf = one_word({$urandom(), $urandom()}, $urandom(), {$urandom(), $urandom()},
			WORD_BYTES_MAX);
		kg = one_word({$urandom(), $urandom()}, $urandom(), {$urandom(), $urandom()}, 4'd6);
		wait_drained(1'b1);
		set_reg(REG_LOCK_TAG_MASK, '0);
		send_request(kf, REQ_POPULATE, TOP_BIT);
		send_request(kf, REQ_VERIFY, TOP_BIT);
		wait_drained(1'b1);
		// The stored word now reads as a lock.
		set_reg(REG_LOCK_TAG_MASK, TOP_BIT);
		send_request(kf, REQ_POPULATE, 64'd5);
		send_request(kf, REQ_VERIFY, TOP_BIT);
		wait_drained(1'b1);
		set_reg(REG_LOCK_TAG_MASK, '1);
		send_request(kg, REQ_POPULATE, 64'd1);
		wait_drained(1'b1);
		set_reg(REG_LOCK_TAG_MASK, 64'd1);
		send_request(kg, REQ_POPULATE, 64'd2);
		send_request(kg, REQ_POPULATE, 64'd3);
		send_request(kg, REQ_VERIFY, 64'd2);
	endtask

	task automatic test_output_backpressure();
		wait_drained(1'b0);
		tx_gaps_on = 1'b0;
		rx_hold_req = 600;
		run_traffic(16);
		wait_drained(1'b0);
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int p;
		for (p = 0; p < 5; p++) begin
			wait_drained(1'b1);
			case (p)
				0: begin
					set_reg(REG_HASH_SEED, '0);
					set_reg(REG_LOCK_TAG_MASK, TOP_BIT);
				end
				1: begin
					set_reg(REG_HASH_SEED, '1);
					set_reg(REG_LOCK_TAG_MASK, (64'd1 << $urandom_range(0, 63)) |
						(64'd1 << $urandom_range(0, 63)));
				end
				2: begin
					set_reg(REG_HASH_SEED, {$urandom(), $urandom()});
					set_reg(REG_LOCK_TAG_MASK, '0);
				end
				3: begin
					set_reg(REG_HASH_SEED, {$urandom(), $urandom()});
					set_reg(REG_LOCK_TAG_MASK, '1);
				end
				default: begin
					set_reg(REG_HASH_SEED, {$urandom(), $urandom()});
					set_reg(REG_LOCK_TAG_MASK, TOP_BIT);
				end
			endcase
			tx_gaps_on = (p != 2);
			rx_stall_on = (p != 2) && (p != 3);
			run_traffic((p == 3) ? 60 : 140);
		end
		tx_gaps_on = 1'b1;
		rx_stall_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		int n;
		for (n = 0; n < 3; n++) begin
			run_traffic(25);
			wait_drained(1'b0);
		end
	endtask

	initial begin : rx_side
		int unsigned hold_left;
		int unsigned run_left;
		logic        stalling;
		hold_left = 0;
		run_left = 0;
		stalling = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!rx_stall_on) begin
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stalling = !stalling;
					run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (slot_verdicts.size() == 0) begin
				$error("unexpected result beat: ok %0d, slot_index %0d", ok, slot_index);
				fail_count++;
			end else begin
				want = slot_verdicts.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, actual %0d", want.ok, ok);
					fail_count++;
				end
				if (slot_index !== want.slot) begin
					$error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("hashed_version_slot_table_core: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_HASH_SEED;
		cfg_data <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_VERIFY;
		db_handle <= '0;
		column_id <= '0;
		key_word <= '0;
		word_bytes <= '0;
		key_last <= 1'b0;
		version <= '0;
		foreach (slot_mem[j]) begin
			slot_mem[j] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_lock_tags();
		test_output_backpressure();
		test_random_traffic();
		test_sender_pause();
		wait_drained(1'b1);
		if (fail_count == 0) begin
			$display("hashed_version_slot_table_core: match");
		end else begin
			$display("hashed_version_slot_table_core: mismatch");
		end
		$finish;
	end

endmodule
